// ----- sv/wwct_pkg.sv -----
package wwct_pkg;

    // sizing
    localparam int LINE_CAPACITY  = 40;
    localparam int SCREEN_COLUMNS = 40;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 6;
    localparam int TILE_W  = 16;
    localparam int LINES_W = 8;
    localparam int FONT_W  = 11;
    localparam int PAL_W   = 2;
    localparam int WRAP_W  = 6;
    localparam int GLYPH_W = 7;

    // derived widths
    localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W = $clog2(LINE_CAPACITY);
    localparam int SC_W   = $clog2(SCREEN_COLUMNS + 1);
    localparam int WCMP_W = (LEN_W > WRAP_W) ? LEN_W : WRAP_W;
    localparam int EM_W   = (LEN_W > SC_W) ? LEN_W : SC_W;

    // stream packing
    localparam int IN_TDATA_W   = 8;
    localparam int TD_ROW_LSB   = 0;
    localparam int TD_COL_LSB   = TD_ROW_LSB + ROW_W;
    localparam int TD_TILE_LSB  = TD_COL_LSB + COL_W;
    localparam int TD_LINES_LSB = TD_TILE_LSB + TILE_W;
    localparam int TD_USED_W    = TD_LINES_LSB + LINES_W;
    localparam int OUT_TDATA_W  = ((TD_USED_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FONT_BASE    = 3'd0,
        CFG_PALETTE      = 3'd1,
        CFG_WRAP_WIDTH   = 3'd2,
        CFG_BASE_ROW     = 3'd3,
        CFG_TARGET_PLANE = 3'd4
    } t_cfg_idx;

    localparam logic [WRAP_W-1:0]  WRAP_RESET = 6'd40;

    // character codes
    localparam logic [CHAR_W-1:0]  END_CODE     = 8'd0;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0]  PRINT_LAST   = 8'd126;
    localparam logic [CHAR_W-1:0]  ACCENT_FIRST = 8'd1;
    localparam logic [CHAR_W-1:0]  ACCENT_LAST  = 8'd6;
    localparam logic [GLYPH_W-1:0] ACCENT_GLYPH = 7'd95;
    localparam logic [LINES_W-1:0] LINES_MAX    = 8'd255;

    // result kinds
    localparam logic KIND_TILE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic emit_wr;
        logic line_done;
        logic scan_sel;
        logic scan_wr;
        logic append_held;
        logic end_wr;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_end;
        logic in_brk;
        logic emit_done;
        logic flush;
        logic scan_done;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/word_wrap_center_tile_writer.sv -----
// Word wrapper that turns a text stream into centered rows of tile writes.
// Slave stream: one text byte per beat in s_axis_tdata; code 0 ends the text.
// Master stream: one result per beat. tuser low is a tile write (row, column,
// tile word), tlast marks the last tile of a line; tuser high is the end of
// text beat carrying the line count in the lines_used field.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_wr_en
// is high, only while the block is idle.
// Ordinary characters are accepted back to back while the block is idle. A
// line break or the end of text holds the input while the line is emitted:
// each tile is read from the line store and then written to the output
// register, which waits while the output is not free. After a break the
// characters carried over are read back and appended again. The single
// line store, with its registered read port, serves both the tile emission
// and the rescan.
// Reset (i_rst_n low, synchronous) empties the line, clears the line count
// and restores the register defaults. When the receiver stalls, the held
// result stays on the master port and the block waits without losing data.
module word_wrap_center_tile_writer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [wwct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wwct_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // text input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // fields: [7:0] char_code
    input  logic [wwct_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // fields: [7:0] screen_row, [13:8] screen_column, [29:14] tile_word,
    // [37:30] lines_used, [39:38] zero
    output logic [wwct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // fields: [0] kind
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import wwct_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    wwct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wwct_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

// ----- sv/wwct_ram.sv -----
module wwct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/wwct_ctrl.sv -----
module wwct_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  wwct_pkg::t_dp_status i_status,
    output wwct_pkg::t_dp_cmd    o_cmd
);
    import wwct_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EMIT_RD = 6'b000010,
        S_EMIT_WR = 6'b000100,
        S_SCAN_RD = 6'b001000,
        S_SCAN_WR = 6'b010000,
        S_END_WR  = 6'b100000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_status.in_end || i_status.in_brk) begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                if (i_status.emit_done) begin
                    cmd.line_done = 1'b1;
                    n_state = i_status.flush ? S_END_WR : S_SCAN_RD;
                end else begin
                    n_state = S_EMIT_WR;
                end
            end
            S_EMIT_WR: begin
                if (i_status.out_free) begin
                    cmd.emit_wr = 1'b1;
                    n_state = S_EMIT_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.scan_sel = 1'b1;
                if (i_status.scan_done) begin
                    cmd.append_held = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN_WR;
                end
            end
            S_SCAN_WR: begin
                cmd.scan_sel = 1'b1;
                cmd.scan_wr  = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_END_WR: begin
                if (i_status.out_free) begin
                    cmd.end_wr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

// ----- sv/wwct_datapath.sv -----
module wwct_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [wwct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wwct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [wwct_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  wwct_pkg::t_dp_cmd                   i_cmd,
    output wwct_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_out_kind,
    output logic [wwct_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                                o_out_last
);
    import wwct_pkg::*;

    // configuration
    logic [FONT_W-1:0]  r_font_base;
    logic [PAL_W-1:0]   r_palette;
    logic [WRAP_W-1:0]  r_wrap_width;
    logic [ROW_W-1:0]   r_base_row;

    // line state
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_lsp, n_lsp;
    logic [LINES_W-1:0] r_count, n_count;
    logic               r_skip, n_skip;
    logic               r_flush, n_flush;

    // emission and rescan counters
    logic [CHAR_W-1:0]  r_char, n_char;
    logic [LEN_W-1:0]   r_j, n_j;
    logic [LEN_W-1:0]   r_m, n_m;
    logic [COL_W-1:0]   r_col0, n_col0;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [LEN_W-1:0]   r_src, n_src;
    logic [LEN_W-1:0]   r_src_end, n_src_end;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_kind, n_out_kind;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                   r_out_last, n_out_last;

    // memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CHAR_W-1:0] ram_rd_data;

    // combinational helpers
    logic [CHAR_W-1:0]  in_char;
    logic               in_end;
    logic               in_brk;
    logic [WCMP_W-1:0]  eff_w;
    logic [LEN_W-1:0]   cut;
    logic [LEN_W-1:0]   emit_n;
    logic               emit_full;
    logic [EM_W-1:0]    margin;
    logic               app_en;
    logic [CHAR_W-1:0]  app_char;
    logic               app_keep;
    logic               app_room;
    logic               out_free;
    logic [TILE_W-1:0]  tile;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row_start;

    // glyph offset of a stored code
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
        logic [GLYPH_W-1:0] off;
        off = '0;
        if (c >= SPACE_CODE && c <= PRINT_LAST) begin
            off = GLYPH_W'(c - SPACE_CODE);
        end else if (c >= ACCENT_FIRST && c <= ACCENT_LAST) begin
            off = ACCENT_GLYPH + GLYPH_W'(c - ACCENT_FIRST);
        end
        return off;
    endfunction

    wwct_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_len[ADDR_W-1:0]),
        .i_wr_data (app_char),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // input decode and break test
    always_comb begin
        in_char = i_in_data[CHAR_W-1:0];
        in_end  = (in_char == END_CODE);
        if (r_wrap_width == '0) begin
            eff_w = WCMP_W'(1);
        end else if (WCMP_W'(r_wrap_width) > WCMP_W'(LINE_CAPACITY)) begin
            eff_w = WCMP_W'(LINE_CAPACITY);
        end else begin
            eff_w = WCMP_W'(r_wrap_width);
        end
        in_brk = !in_end && !(r_skip && in_char == SPACE_CODE)
                 && (WCMP_W'(r_len) >= eff_w);
    end

    // line geometry for the line about to go out
    always_comb begin
        cut = (r_lsp != '0) ? r_lsp : r_len;
        if (cut > r_len) begin
            cut = r_len;
        end
        emit_n    = in_end ? r_len : cut;
        emit_full = (EM_W'(emit_n) >= EM_W'(SCREEN_COLUMNS));
        margin    = EM_W'(SCREEN_COLUMNS) - EM_W'(emit_n);
        row_start = r_base_row + {r_count[LINES_W-2:0], 1'b0};
    end

    // character append, shared by input, rescan and held character
    always_comb begin
        app_en = (i_cmd.accept && !in_end && !in_brk) || i_cmd.scan_wr
                 || i_cmd.append_held;
        if (i_cmd.scan_wr) begin
            app_char = ram_rd_data;
        end else if (i_cmd.accept) begin
            app_char = in_char;
        end else begin
            app_char = r_char;
        end
        app_keep = !(r_skip && app_char == SPACE_CODE);
        app_room = (r_len < LEN_W'(LINE_CAPACITY));
        ram_we   = app_en && app_keep && app_room;
    end

    assign ram_rd_addr = i_cmd.scan_sel ? r_src[ADDR_W-1:0] : r_j[ADDR_W-1:0];

    // tile word of the character being read
    always_comb begin
        tile = {1'b1, r_palette, 2'b00, r_font_base + FONT_W'(glyph_of(ram_rd_data))};
        col  = r_col0 + COL_W'(r_j);
    end

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_len       = r_len;
        n_lsp       = r_lsp;
        n_count     = r_count;
        n_skip      = r_skip;
        n_flush     = r_flush;
        n_char      = r_char;
        n_j         = r_j;
        n_m         = r_m;
        n_col0      = r_col0;
        n_row       = r_row;
        n_src       = r_src;
        n_src_end   = r_src_end;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        // output register drains
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // line set-up on end of text or on a break
        if (i_cmd.accept && (in_end || in_brk)) begin
            n_flush   = in_end;
            n_char    = in_char;
            n_j       = '0;
            n_m       = emit_full ? LEN_W'(SCREEN_COLUMNS) : emit_n;
            n_col0    = emit_full ? '0 : COL_W'(margin >> 1);
            n_row     = row_start;
            n_src     = cut;
            n_src_end = r_len;
        end

        // append a character
        if (app_en && app_keep) begin
            n_skip = 1'b0;
            if (app_room) begin
                if (app_char == SPACE_CODE) begin
                    n_lsp = r_len;
                end
                n_len = r_len + LEN_W'(1);
            end
        end

        // rescan advance
        if (i_cmd.scan_wr) begin
            n_src = r_src + LEN_W'(1);
        end

        // one tile write
        if (i_cmd.emit_wr) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_TILE;
            n_out_data  = OUT_TDATA_W'({{LINES_W{1'b0}}, tile, col, r_row});
            n_out_last  = (r_j + LEN_W'(1) == r_m);
            n_j         = r_j + LEN_W'(1);
        end

        // line finished
        if (i_cmd.line_done) begin
            if (r_count != LINES_MAX) begin
                n_count = r_count + LINES_W'(1);
            end
            if (!r_flush) begin
                n_len  = '0;
                n_lsp  = '0;
                n_skip = 1'b1;
            end
        end

        // end of text result
        if (i_cmd.end_wr) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_END;
            n_out_data  = OUT_TDATA_W'({r_count, {(TD_LINES_LSB){1'b0}}});
            n_out_last  = 1'b0;
            n_len       = '0;
            n_lsp       = '0;
            n_count     = '0;
            n_skip      = 1'b0;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_base  <= '0;
            r_palette    <= '0;
            r_wrap_width <= WRAP_RESET;
            r_base_row   <= '0;
            r_len        <= '0;
            r_lsp        <= '0;
            r_count      <= '0;
            r_skip       <= 1'b0;
            r_flush      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_lsp       <= n_lsp;
            r_count     <= n_count;
            r_skip      <= n_skip;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FONT_BASE:    r_font_base  <= i_cfg_data[FONT_W-1:0];
                    CFG_PALETTE:      r_palette    <= i_cfg_data[PAL_W-1:0];
                    CFG_WRAP_WIDTH:   r_wrap_width <= i_cfg_data[WRAP_W-1:0];
                    CFG_BASE_ROW:     r_base_row   <= i_cfg_data[ROW_W-1:0];
                    // plane select does not show in the tile stream
                    CFG_TARGET_PLANE: ;
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_j        <= n_j;
        r_m        <= n_m;
        r_col0     <= n_col0;
        r_row      <= n_row;
        r_src      <= n_src;
        r_src_end  <= n_src_end;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    always_comb begin
        o_status.in_end    = in_end;
        o_status.in_brk    = in_brk;
        o_status.emit_done = (r_j == r_m);
        o_status.flush     = r_flush;
        o_status.scan_done = (r_src == r_src_end);
        o_status.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

// ----- sv/wwct_checker.sv -----
module wwct_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [wwct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                               m_axis_tuser,
    input logic                               m_axis_tlast
);
    import wwct_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // end beats carry only the line count
    a_end_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            !m_axis_tlast && m_axis_tdata[TD_LINES_LSB-1:0] == '0)
        else $error("end beat carries tile fields");

    // tile beats have the top tile bit set and no line count
    a_tile_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[TD_TILE_LSB+15]
            && m_axis_tdata[TD_USED_W-1:TD_LINES_LSB] == '0)
        else $error("malformed tile beat");

endmodule

bind word_wrap_center_tile_writer wwct_checker u_wwct_checker (.*);

// ----- tb/tb_word_wrap_center_tile_writer.sv -----
`timescale 1ns / 1ps

module tb_word_wrap_center_tile_writer;
    import wwct_pkg::*;

    localparam int RAND_ITEMS    = 24;
    localparam int SAT_CHARS     = 258;
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_CYCLES  = 200;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_CFG,
        OP_DRAIN
    } t_text_op;

    typedef struct {
        t_text_op              op;
        logic [CHAR_W-1:0]     code;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] value;
    } t_text_entry;

    typedef struct {
        logic               kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [TILE_W-1:0]  tile;
        logic               last;
        logic [LINES_W-1:0] used;
    } t_tile_beat;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;

    word_wrap_center_tile_writer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // pending text bytes and register writes, expected output beats
    t_text_entry pending[$];
    t_tile_beat  beats_due[$];

    // shadow registers and line state of the wrapper
    logic [FONT_W-1:0]  font_q = '0;
    logic [PAL_W-1:0]   pal_q = '0;
    logic [WRAP_W-1:0]  wrap_q = WRAP_RESET;
    logic [ROW_W-1:0]   row_base_q = '0;
    logic [CHAR_W-1:0]  line_buf[LINE_CAPACITY];
    int                 line_len = 0;
    int                 space_pos = 0;
    int                 lines_done = 0;
    bit                 drop_spaces = 1'b0;

    // run bookkeeping
    bit  live = 1'b0;
    bit  char_taken = 1'b0;
    bit  stim_done = 1'b0;
    bit  send_calm = 1'b0;
    bit  sink_calm = 1'b0;
    int  calm_timer = 0;
    int  text_gap = 0;
    int  sink_stall = 0;
    int  idle_cycles = 0;
    int  mismatches = 0;
    int  bytes_taken = 0;
    int  tiles_seen = 0;
    int  texts_seen = 0;
    int  queued_chars = 0;

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // tile word for one stored character
    function automatic logic [TILE_W-1:0] tile_of(input logic [CHAR_W-1:0] c);
        logic [FONT_W-1:0] glyph;
        glyph = '0;
        if (c >= SPACE_CODE && c <= PRINT_LAST)
            glyph = c - SPACE_CODE;
        else if (c >= ACCENT_FIRST && c <= ACCENT_LAST)
            glyph = ACCENT_GLYPH + (c - ACCENT_FIRST);
        return {1'b1, pal_q, 2'b00, FONT_W'(font_q + glyph)};
    endfunction

    // centered row of tile writes for the first n stored characters
    task automatic emit_row(input int n);
        int         first_col;
        int         cnt;
        int         j;
        t_tile_beat b;
        first_col = (n >= SCREEN_COLUMNS) ? 0 : (SCREEN_COLUMNS - n) / 2;
        cnt = n;
        if (first_col + cnt > SCREEN_COLUMNS) cnt = SCREEN_COLUMNS - first_col;
        for (j = 0; j < cnt; j++) begin
            b.kind = KIND_TILE;
            b.row  = row_base_q + ROW_W'(2 * lines_done);
            b.col  = COL_W'(first_col + j);
            b.tile = tile_of(line_buf[j]);
            b.last = (j + 1 == cnt);
            b.used = '0;
            beats_due.push_back(b);
        end
        if (lines_done < LINES_MAX) lines_done++;
    endtask

    task automatic place_char(input logic [CHAR_W-1:0] c);
        if (!(drop_spaces && c == SPACE_CODE)) begin
            drop_spaces = 1'b0;
            if (line_len < LINE_CAPACITY) begin
                if (c == SPACE_CODE) space_pos = line_len;
                line_buf[line_len] = c;
                line_len++;
            end
        end
    endtask

    // one text byte through the wrapper
    task automatic wrap_char(input logic [CHAR_W-1:0] c);
        int                eff;
        int                cut;
        int                rest_n;
        int                j;
        logic [CHAR_W-1:0] carry[LINE_CAPACITY];
        t_tile_beat        b;
        if (c == END_CODE) begin
            emit_row(line_len);
            b.kind = KIND_END;
            b.row  = '0;
            b.col  = '0;
            b.tile = '0;
            b.last = 1'b0;
            b.used = LINES_W'(lines_done);
            beats_due.push_back(b);
            line_len    = 0;
            space_pos   = 0;
            lines_done  = 0;
            drop_spaces = 1'b0;
        end else begin
            eff = (wrap_q == 0) ? 1 : (wrap_q > LINE_CAPACITY) ? LINE_CAPACITY : wrap_q;
            if (!(drop_spaces && c == SPACE_CODE) && line_len >= eff) begin
                cut = (space_pos != 0) ? space_pos : line_len;
                rest_n = line_len - cut;
                for (j = 0; j < rest_n; j++) carry[j] = line_buf[cut + j];
                emit_row(cut);
                line_len    = 0;
                space_pos   = 0;
                drop_spaces = 1'b1;
                for (j = 0; j < rest_n; j++) place_char(carry[j]);
            end
            place_char(c);
        end
    endtask

    task automatic check_beat();
        t_tile_beat       want;
        logic [ROW_W-1:0] got_row;
        logic [COL_W-1:0] got_col;
        logic [TILE_W-1:0] got_tile;
        logic [LINES_W-1:0] got_used;
        got_row  = m_axis_tdata[TD_ROW_LSB +: ROW_W];
        got_col  = m_axis_tdata[TD_COL_LSB +: COL_W];
        got_tile = m_axis_tdata[TD_TILE_LSB +: TILE_W];
        got_used = m_axis_tdata[TD_LINES_LSB +: LINES_W];
        if (beats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected beat kind=%0d row=%0d col=%0d tile=%h used=%0d",
                         $realtime, m_axis_tuser, got_row, got_col, got_tile, got_used);
        end else begin
            want = beats_due.pop_front();
            if (m_axis_tuser == KIND_END) texts_seen++;
            else tiles_seen++;
            if (m_axis_tuser !== want.kind || got_row !== want.row ||
                got_col !== want.col || got_tile !== want.tile ||
                m_axis_tlast !== want.last || got_used !== want.used) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: beat mismatch exp kind=%0d row=%0d col=%0d tile=%h",
                             $realtime, want.kind, want.row, want.col, want.tile);
                    $display("    exp last=%0d used=%0d", want.last, want.used);
                    $display("    act kind=%0d row=%0d col=%0d tile=%h last=%0d used=%0d",
                             m_axis_tuser, got_row, got_col, got_tile, m_axis_tlast,
                             got_used);
                end
            end
        end
    endtask

    // monitor: register writes, accepted bytes and output beats at the rising edge
    always @(posedge i_clk) begin
        live <= i_rst_n;
        char_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FONT_BASE:    font_q = i_cfg_data[FONT_W-1:0];
                    CFG_PALETTE:      pal_q = i_cfg_data[PAL_W-1:0];
                    CFG_WRAP_WIDTH:   wrap_q = i_cfg_data[WRAP_W-1:0];
                    CFG_BASE_ROW:     row_base_q = i_cfg_data[ROW_W-1:0];
                    // plane select does not show in the tile stream
                    CFG_TARGET_PLANE: ;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_taken++;
                wrap_char(s_axis_tdata[CHAR_W-1:0]);
            end
            if (m_axis_tvalid && m_axis_tready) check_beat();
        end
    end

    // stretches without idling on either side
    always @(posedge i_clk) begin
        if (calm_timer == 0) begin
            send_calm  <= ($urandom_range(0, 3) == 0);
            sink_calm  <= ($urandom_range(0, 3) == 0);
            calm_timer <= $urandom_range(50, 400);
        end else begin
            calm_timer <= calm_timer - 1;
        end
    end

    // text driver; register writes and pauses wait until every beat is out
    always @(negedge i_clk) begin : drive_text
        logic next_valid;
        logic next_wr;
        next_valid = s_axis_tvalid;
        next_wr    = 1'b0;
        if (live && !(s_axis_tvalid && !char_taken)) begin
            next_valid = 1'b0;
            if (text_gap > 0) begin
                text_gap--;
            end else if (pending.size() == 0) begin
                stim_done = 1'b1;
            end else if (pending[0].op == OP_CHAR) begin
                s_axis_tdata <= pending[0].code;
                next_valid = 1'b1;
                void'(pending.pop_front());
                text_gap = pick_gap(send_calm);
                idle_cycles = 0;
            end else if (beats_due.size() != 0) begin
                idle_cycles = 0;
            end else if (idle_cycles < SETTLE_CYCLES) begin
                idle_cycles++;
            end else begin
                if (pending[0].op == OP_CFG) begin
                    i_cfg_index <= pending[0].idx;
                    i_cfg_data  <= pending[0].value;
                    next_wr = 1'b1;
                end
                void'(pending.pop_front());
            end
        end
        s_axis_tvalid <= next_valid;
        i_cfg_wr_en   <= next_wr;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            sink_stall = pick_gap(sink_calm);
        end
    end

    task automatic add_char(input int c);
        t_text_entry e;
        e.op = OP_CHAR;
        e.code = CHAR_W'(c);
        e.idx = CFG_FONT_BASE;
        e.value = '0;
        pending.push_back(e);
        queued_chars++;
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input int value);
        t_text_entry e;
        e.op = OP_CFG;
        e.code = '0;
        e.idx = idx;
        e.value = CFG_DATA_W'(value);
        pending.push_back(e);
    endtask

    task automatic add_drain();
        t_text_entry e;
        e.op = OP_DRAIN;
        e.code = '0;
        e.idx = CFG_FONT_BASE;
        e.value = '0;
        pending.push_back(e);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    // mostly printable letters, some accented, a few codes drawn as blanks
    function automatic int rand_letter();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(ACCENT_FIRST, ACCENT_LAST);
        if (r == 1) return ($urandom_range(0, 1)) ? $urandom_range(7, 31)
                                                   : $urandom_range(127, 255);
        return $urandom_range(33, 126);
    endfunction

    function automatic int pick_width();
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0: return 0;
            1: return 1;
            2: return 63;
            3: return 40;
            4: return $urandom_range(41, 62);
            5, 6: return $urandom_range(13, 39);
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    initial begin
        int i;
        int w;
        int eff;
        int words;
        int wlen;
        int rand_start;

        // empty text, then default registers: leading spaces, every glyph class
        add_char(END_CODE);
        add_text("  A");
        add_drain();
        add_char(1);
        add_char(6);
        add_char(7);
        add_char(31);
        add_char(126);
        add_char(127);
        add_char(128);
        add_char(255);
        add_char(END_CODE);

        // register extremes, width 0 acts as 1, rows wrap past 255
        add_cfg(CFG_FONT_BASE, 2047);
        add_cfg(CFG_PALETTE, 3);
        add_cfg(CFG_WRAP_WIDTH, 0);
        add_cfg(CFG_BASE_ROW, 255);
        add_cfg(CFG_TARGET_PLANE, 3);
        add_text("A B");
        add_char(END_CODE);

        // space at line start, hard break, trailing spaces after a break
        add_cfg(CFG_WRAP_WIDTH, 4);
        add_text(" abcd e  ");
        add_char(END_CODE);

        // line count saturation with one character per line
        add_cfg(CFG_WRAP_WIDTH, 1);
        add_cfg(CFG_BASE_ROW, 7);
        add_cfg(CFG_FONT_BASE, 0);
        add_cfg(CFG_PALETTE, 0);
        for (i = 0; i < SAT_CHARS; i++) add_char($urandom_range(33, 126));
        add_char(END_CODE);

        // random texts of words with random register settings
        eff = 1;
        rand_start = queued_chars;
        while (queued_chars - rand_start < RAND_ITEMS) begin
            if ($urandom_range(0, 1)) begin
                w = pick_width();
                add_cfg(CFG_WRAP_WIDTH, w);
                eff = (w == 0) ? 1 : (w > LINE_CAPACITY) ? LINE_CAPACITY : w;
                if ($urandom_range(0, 1)) add_cfg(CFG_FONT_BASE, $urandom_range(0, 2047));
                if ($urandom_range(0, 1)) add_cfg(CFG_PALETTE, $urandom_range(0, 3));
                if ($urandom_range(0, 1)) add_cfg(CFG_BASE_ROW, $urandom_range(0, 255));
                if ($urandom_range(0, 2) == 0)
                    add_cfg(CFG_TARGET_PLANE, $urandom_range(0, 3));
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise: any nonzero code, biased toward spaces
                wlen = $urandom_range(1, 30);
                for (i = 0; i < wlen; i++)
                    add_char(($urandom_range(0, 3) == 0) ? SPACE_CODE
                                                         : $urandom_range(1, 255));
            end else begin
                if ($urandom_range(0, 5) == 0) add_text("  ");
                words = $urandom_range(1, 8);
                while (words > 0) begin
                    if ($urandom_range(0, 7) == 0)
                        wlen = $urandom_range(eff, (eff + 5 > 45) ? 45 : eff + 5);
                    else
                        wlen = $urandom_range(1, (eff < 10) ? eff : 10);
                    for (i = 0; i < wlen; i++) add_char(rand_letter());
                    words--;
                    if (words > 0) begin
                        add_char(SPACE_CODE);
                        if ($urandom_range(0, 4) == 0) add_text("  ");
                        if ($urandom_range(0, 24) == 0) add_drain();
                    end
                end
                if ($urandom_range(0, 4) == 0) add_text("   ");
            end
            add_char(END_CODE);
        end

        // reset, then wait for the stream to finish
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (!stim_done) @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d text bytes in %0d texts, %0d tile writes checked",
                 bytes_taken, texts_seen, tiles_seen);
        $display("widths 0, 1, 4 and random, line count saturation, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("[word_wrap_center_tile_writer] OK");
        end else begin
            $display("[word_wrap_center_tile_writer] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(50_000_000);
        $display("[word_wrap_center_tile_writer] ERROR");
        $finish;
    end

endmodule
